/* rtl/core/x86_register_usage_decoder_unit_assert.svh */
// Assertion macros shared by the decoder RTL.
// Each macro expects clk and arst_n to be visible at the place of use.
`ifndef X86_REGISTER_USAGE_DECODER_UNIT_ASSERT_SVH
`define X86_REGISTER_USAGE_DECODER_UNIT_ASSERT_SVH

// Check that a condition holds at every clock edge outside reset.
`define XRUD_ASSERT_HOLDS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a trigger in one cycle implies a condition in the next cycle.
`define XRUD_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

/* rtl/core/xrud_pkg.sv */
package xrud_pkg;

	// Fixed widths and defaults
	localparam int COUNT_W = 4;
	localparam int MAX_INSTR_BYTES_DEF = 15;

	// Mask bits
	localparam logic [31:0] MASK_RIP = 32'h0001_0000;
	localparam logic [31:0] MASK_FLAGS = 32'h4000_0000;
	localparam logic [31:0] MASK_MEM = 32'h8000_0000;
	localparam logic [31:0] MASK_LOW_REGS = 32'h0000_ffff;
	localparam logic [31:0] MASK_UNKNOWN = 32'hffff_ffff;

	// Legacy prefix bytes
	localparam logic [7:0] PFX_ES = 8'h26;
	localparam logic [7:0] PFX_CS = 8'h2e;
	localparam logic [7:0] PFX_SS = 8'h36;
	localparam logic [7:0] PFX_DS = 8'h3e;
	localparam logic [7:0] PFX_FS = 8'h64;
	localparam logic [7:0] PFX_GS = 8'h65;
	localparam logic [7:0] PFX_OPSIZE = 8'h66;
	localparam logic [7:0] PFX_ADSIZE = 8'h67;
	localparam logic [7:0] PFX_LOCK = 8'hf0;

	// Mandatory prefix and escape bytes
	localparam logic [7:0] PFX_ESCAPE = 8'h0f;
	localparam logic [7:0] PFX_REPNE = 8'hf2;
	localparam logic [7:0] PFX_REP = 8'hf3;
	localparam logic [7:0] PFX_WAIT = 8'h9b;

	// REX byte high nibble
	localparam logic [3:0] REX_HI = 4'h4;

	// Supported opcodes
	localparam logic [7:0] OP_ADD_RM8 = 8'h00;
	localparam logic [7:0] OP_ADD_RM = 8'h01;
	localparam logic [7:0] OP_SUB_RM = 8'h29;
	localparam logic [4:0] OP_PUSH_HI = 5'b01010;
	localparam logic [4:0] OP_POP_HI = 5'b01011;
	localparam logic [7:0] OP_GRP1_IMM = 8'h81;
	localparam logic [7:0] OP_GRP1_IMM8 = 8'h83;
	localparam logic [7:0] OP_TEST = 8'h85;
	localparam logic [7:0] OP_XCHG = 8'h87;
	localparam logic [7:0] OP_MOV_ST = 8'h89;
	localparam logic [7:0] OP_MOV_LD = 8'h8b;
	localparam logic [4:0] OP_MOV_IMM_HI = 5'b10111;

	// ModRM codes
	localparam logic [1:0] MOD_REG = 2'b11;
	localparam logic [1:0] MOD_NODISP = 2'b00;
	localparam logic [2:0] RM_SIB = 3'b100;
	localparam logic [2:0] RM_DISP32 = 3'b101;
	localparam logic [2:0] REG_RSP = 3'b100;

	typedef enum logic [2:0] {
		PH_PREFIX,
		PH_MODRM,
		PH_EXT,
		PH_SIB,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic last_byte;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] src_mask;
		logic [31:0] dst_mask;
	} out_beat_t;

	typedef struct packed {
		phase_t phase;
		logic [COUNT_W-1:0] count;
		logic [2:0] rex;
		logic mand;
		logic [7:0] opcode;
		logic [7:0] modrm;
		logic [31:0] src;
		logic [31:0] dst;
	} dec_state_t;

	typedef struct packed {
		logic supported;
		logic modrm;
		logic ext;
		logic merge_src;
		logic merge_dst;
		logic [31:0] src_flags;
		logic [31:0] dst_flags;
	} op_desc_t;

	localparam dec_state_t RESET_STATE = '{
		phase: PH_PREFIX,
		count: '0,
		rex: 3'b000,
		mand: 1'b0,
		opcode: 8'h00,
		modrm: 8'h00,
		src: MASK_UNKNOWN,
		dst: MASK_UNKNOWN
	};

	// One-hot register bit for a 3-bit register number and its REX extension
	function automatic logic [31:0] gp_bit(logic [2:0] num, logic ext);
		logic [15:0] one_hot;
		one_hot = 16'b1 << {ext, num};
		return {16'h0000, one_hot};
	endfunction

	function automatic logic is_legacy(logic [7:0] b);
		return (b == PFX_ES) || (b == PFX_CS) || (b == PFX_SS) || (b == PFX_DS) ||
			(b == PFX_FS) || (b == PFX_GS) || (b == PFX_OPSIZE) ||
			(b == PFX_ADSIZE) || (b == PFX_LOCK);
	endfunction

	function automatic logic is_mandatory(logic [7:0] b);
		return (b == PFX_ESCAPE) || (b == PFX_REPNE) || (b == PFX_REP) || (b == PFX_WAIT);
	endfunction

	// Opcode attributes: operand bytes awaited, merges and flag bits
	function automatic op_desc_t describe(logic [7:0] op);
		op_desc_t d;
		d = '{supported: 1'b1, modrm: 1'b0, ext: 1'b0, merge_src: 1'b0, merge_dst: 1'b0,
			src_flags: 32'h0, dst_flags: 32'h0};
		if (op == OP_ADD_RM8 || op == OP_ADD_RM || op == OP_SUB_RM) begin
			d.modrm = 1'b1;
			d.merge_dst = 1'b1;
			d.dst_flags = MASK_FLAGS;
		end else if (op[7:3] == OP_PUSH_HI) begin
			d.merge_dst = 1'b1;
			d.dst_flags = MASK_MEM;
		end else if (op[7:3] == OP_POP_HI) begin
			d.merge_src = 1'b1;
			d.src_flags = MASK_MEM;
		end else if (op == OP_GRP1_IMM || op == OP_GRP1_IMM8) begin
			d.ext = 1'b1;
			d.merge_dst = 1'b1;
			d.dst_flags = MASK_FLAGS;
		end else if (op == OP_TEST) begin
			d.modrm = 1'b1;
			d.merge_src = 1'b1;
			d.dst_flags = MASK_FLAGS;
		end else if (op == OP_XCHG) begin
			d.modrm = 1'b1;
			d.merge_src = 1'b1;
			d.merge_dst = 1'b1;
		end else if (op == OP_MOV_ST) begin
			d.modrm = 1'b1;
		end else if (op == OP_MOV_LD) begin
			d.modrm = 1'b1;
			d.merge_src = 1'b1;
		end else if (op[7:3] == OP_MOV_IMM_HI) begin
			d.supported = 1'b1;
		end else begin
			d.supported = 1'b0;
		end
		return d;
	endfunction

	// Apply the register merges and then the flag bits of the opcode
	function automatic out_beat_t finish(logic [7:0] op, logic [31:0] src, logic [31:0] dst);
		op_desc_t d;
		logic [31:0] s;
		logic [31:0] t;
		d = describe(op);
		s = src;
		t = dst;
		if (d.merge_dst) s = s | (t & MASK_LOW_REGS);
		if (d.merge_src) t = t | (s & MASK_LOW_REGS);
		s = s | d.src_flags;
		t = t | d.dst_flags;
		return '{src_mask: s, dst_mask: t};
	endfunction

endpackage

/* rtl/core/xrud_step.sv */
module xrud_step
	import xrud_pkg::*;
#(
	parameter int MAX_INSTR_BYTES = MAX_INSTR_BYTES_DEF
) (
	input dec_state_t st,
	input in_beat_t beat,
	output dec_state_t nxt,
	output out_beat_t result
);

	// Decode one byte against the current state
	always_comb begin : step_logic
		op_desc_t d;
		out_beat_t fin;
		logic [7:0] b;
		logic [31:0] s;
		logic [31:0] t;
		logic [1:0] md;
		logic [2:0] rm;
		b = beat.code_byte;
		nxt = st;
		d = describe(b);
		s = st.src;
		t = st.dst;
		md = b[7:6];
		rm = b[2:0];
		fin = '{src_mask: st.src, dst_mask: st.dst};
		if (st.phase != PH_DONE && st.count < COUNT_W'(MAX_INSTR_BYTES)) begin
			nxt.count = st.count + COUNT_W'(1);
			case (st.phase)
				PH_PREFIX: begin
					if (is_mandatory(b)) begin
						nxt.mand = 1'b1;
					end else if (b[7:4] == REX_HI) begin
						nxt.rex = b[2:0];
					end else if (!is_legacy(b)) begin
						// Take the opcode
						if (st.mand || !d.supported) begin
							nxt.phase = PH_DONE;
						end else begin
							nxt.opcode = b;
							s = 32'h0;
							t = 32'h0;
							if (b[7:3] == OP_PUSH_HI) begin
								s = gp_bit(b[2:0], st.rex[0]);
								t = gp_bit(REG_RSP, st.rex[2]);
							end else if (b[7:3] == OP_POP_HI) begin
								s = gp_bit(REG_RSP, st.rex[2]);
								t = gp_bit(b[2:0], st.rex[0]);
							end else if (b[7:3] == OP_MOV_IMM_HI) begin
								t = gp_bit(b[2:0], st.rex[0]);
							end
							fin = finish(b, s, t);
							if (d.ext) begin
								nxt.phase = PH_EXT;
								nxt.src = s;
								nxt.dst = t;
							end else if (d.modrm) begin
								nxt.phase = PH_MODRM;
								nxt.src = s;
								nxt.dst = t;
							end else begin
								nxt.phase = PH_DONE;
								nxt.src = fin.src_mask;
								nxt.dst = fin.dst_mask;
							end
						end
					end
				end
				PH_MODRM: begin
					nxt.modrm = b;
					if (md != MOD_REG && rm == RM_SIB) begin
						nxt.phase = PH_SIB;
					end else begin
						if (md == MOD_NODISP && rm == RM_DISP32) begin
							s = s | MASK_RIP;
							t = t | gp_bit(b[5:3], st.rex[2]);
						end else if (st.opcode[1]) begin
							s = s | gp_bit(rm, st.rex[0]);
							t = t | gp_bit(b[5:3], st.rex[2]);
						end else begin
							s = s | gp_bit(b[5:3], st.rex[2]);
							t = t | gp_bit(rm, st.rex[0]);
						end
						// Memory bit follows the direction bit
						if (md != MOD_REG) begin
							if (st.opcode[1]) s = s | MASK_MEM;
							else t = t | MASK_MEM;
						end
						fin = finish(st.opcode, s, t);
						nxt.phase = PH_DONE;
						nxt.src = fin.src_mask;
						nxt.dst = fin.dst_mask;
					end
				end
				PH_EXT: begin
					t = t | gp_bit(b[2:0], st.rex[0]);
					fin = finish(st.opcode, s, t);
					nxt.phase = PH_DONE;
					nxt.src = fin.src_mask;
					nxt.dst = fin.dst_mask;
				end
				PH_SIB: begin
					s = s | gp_bit(b[5:3], st.rex[1]) | gp_bit(b[2:0], st.rex[0]);
					t = t | gp_bit(st.modrm[5:3], st.rex[2]);
					if (st.opcode[1]) s = s | MASK_MEM;
					else t = t | MASK_MEM;
					fin = finish(st.opcode, s, t);
					nxt.phase = PH_DONE;
					nxt.src = fin.src_mask;
					nxt.dst = fin.dst_mask;
				end
				default: begin
					nxt.phase = PH_DONE;
				end
			endcase
		end
		result = '{src_mask: nxt.src, dst_mask: nxt.dst};
		// Start over after the final byte
		if (beat.last_byte) nxt = RESET_STATE;
	end

endmodule

/* rtl/core/xrud_out.sv */
module xrud_out
	import xrud_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic load,
	input out_beat_t load_beat,
	output logic free,
	output logic out_valid,
	input logic out_ready,
	output out_beat_t out_beat
);

	logic valid_q;
	out_beat_t beat_q;

	// Take a new result when empty or when the held one leaves this cycle
	assign free = !valid_q || out_ready;

	// Hold the valid flag until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Hold the payload while stalled
	always_ff @(posedge clk) begin
		if (load) beat_q <= load_beat;
	end

	assign out_valid = valid_q;
	assign out_beat = beat_q;

endmodule

/* rtl/core/x86_register_usage_decoder_unit.sv */
// Register usage decoder for x86-64 instructions, fed one code byte per beat.
// Input channel: in_valid/in_ready with in_beat (code_byte, last_byte); set
// last_byte on the final available byte of each instruction.
// Output channel: out_valid/out_ready with out_beat (src_mask, dst_mask); one
// result beat per instruction, sent for the byte that carries last_byte.
// Throughput: one byte per cycle unless a final byte waits behind a stalled
// result, with no gap between instructions. Each byte passes an input register,
// then one step of table decode and mask merging that updates the decode state;
// a final byte also loads the result register, which holds the result until it
// is taken.
// Reset clears the input register valid flag, the decode state (prefix phase,
// masks all ones) and the result valid flag.
// When the receiver stalls, the result register holds its beat; the input
// register still takes one more byte, and non-final bytes keep flowing until
// a second final byte waits behind the held result, then in_ready drops.
module x86_register_usage_decoder_unit
	import xrud_pkg::*;
#(
	parameter int MAX_INSTR_BYTES = MAX_INSTR_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_beat_t in_beat,
	output logic out_valid,
	input logic out_ready,
	output out_beat_t out_beat
);

	logic valid_s1;
	in_beat_t beat_s1;
	dec_state_t state_q;
	dec_state_t state_nxt;
	out_beat_t result;
	logic out_free;
	logic adv_s1;

	// Advance the input stage unless a final byte waits on a full result register
	assign adv_s1 = valid_s1 && (!beat_s1.last_byte || out_free);
	assign in_ready = !valid_s1 || adv_s1;

	// Input register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) beat_s1 <= in_beat;
	end

	xrud_step #(
		.MAX_INSTR_BYTES(MAX_INSTR_BYTES)
	) u_step (
		.st(state_q),
		.beat(beat_s1),
		.nxt(state_nxt),
		.result(result)
	);

	// Decode state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RESET_STATE;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	xrud_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(adv_s1 && beat_s1.last_byte),
		.load_beat(result),
		.free(out_free),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_beat(out_beat)
	);

	`include "x86_register_usage_decoder_unit_assert.svh"

	`XRUD_ASSERT_HOLDS(a_blocked_final_waits_on_output, !(valid_s1 && beat_s1.last_byte && !adv_s1) || (out_valid && !out_ready), "final byte blocked without a stalled result")
	`XRUD_ASSERT_NEXT(a_final_restarts_decode, adv_s1 && beat_s1.last_byte, state_q.phase == PH_PREFIX && state_q.count == '0, "decode did not restart after final byte")
	`XRUD_ASSERT_HOLDS(a_count_in_range, state_q.count <= COUNT_W'(MAX_INSTR_BYTES), "byte count beyond maximum length")
	`XRUD_ASSERT_HOLDS(a_prefix_masks_unknown, state_q.phase != PH_PREFIX || (state_q.src == MASK_UNKNOWN && state_q.dst == MASK_UNKNOWN), "masks changed during prefix phase")
	`XRUD_ASSERT_NEXT(a_final_loads_output, adv_s1 && beat_s1.last_byte, out_valid, "final byte did not produce a result")

endmodule
